// File: src/mbpm_pkg.sv
// Shared constants, types and helper functions of the Mandelbrot membership block.
`default_nettype none
package mbpm_pkg;

    // Fixed-point format of the points (signed, FRAC_BITS fraction bits)
    localparam int FRAC_BITS = 28;
    localparam int IN_W      = 32;
    localparam int ITER_W    = 16;

    // Shared multiplier: unsigned magnitudes in, exact product out
    localparam int MAG_W  = IN_W;
    localparam int PROD_W = 2 * MAG_W;

    // Internal width: the widest product shifted by FRAC_BITS-1, plus sign
    localparam int FX_W = PROD_W - (FRAC_BITS - 1) + 1;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(1000);

    typedef logic signed [FX_W-1:0] t_fx;

    // Power-of-two constants
    localparam t_fx FX_ONE       = t_fx'(64'sd1 <<< FRAC_BITS);
    localparam t_fx FX_QUARTER   = t_fx'(64'sd1 <<< (FRAC_BITS - 2));
    localparam t_fx FX_SIXTEENTH = t_fx'(64'sd1 <<< (FRAC_BITS - 4));
    localparam t_fx FX_TWO       = t_fx'(64'sd1 <<< (FRAC_BITS + 1));
    localparam t_fx FX_FOUR      = t_fx'(64'sd1 <<< (FRAC_BITS + 2));

    // Right shift applied to a product
    typedef enum logic [1:0] {
        SH_NORM,    // a*b
        SH_TWICE,   // 2*a*b
        SH_QTR      // a*b/4
    } t_shift;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_DD,
        ST_YQ,
        ST_XP,
        ST_QD,
        ST_CARD,
        ST_CWAIT,
        ST_CDEC,
        ST_SQR,
        ST_SQI,
        ST_PROD,
        ST_ESC,
        ST_STEP,
        ST_DONE
    } t_state;

    // Magnitude above two: escape, and no cardioid or bulb there
    function automatic logic out_of_two(input t_fx v);
        return (v > FX_TWO) || (v < -FX_TWO);
    endfunction

    // Operand magnitude for the unsigned multiplier
    function automatic logic [MAG_W-1:0] mag_of(input t_fx v);
        t_fx a;
        a = (v < 0) ? -v : v;
        return a[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: src/mbpm_ifs.sv
// Valid/ready channel interfaces: point in, verdict out, iteration limit write.
`default_nettype none
interface mbpm_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [mbpm_pkg::IN_W-1:0]    c_real;
    logic signed [mbpm_pkg::IN_W-1:0]    c_imag;
    modport source (output valid, c_real, c_imag, input ready);
    modport sink   (input valid, c_real, c_imag, output ready);
endinterface

interface mbpm_result_if;
    logic valid;
    logic ready;
    logic in_set;
    modport source (output valid, in_set, input ready);
    modport sink   (input valid, in_set, output ready);
endinterface

interface mbpm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mbpm_pkg::ITER_W-1:0]       max_iter;
    modport source (output valid, max_iter, input ready);
    modport sink   (input valid, max_iter, output ready);
endinterface
`default_nettype wire

// File: src/mandelbrot_point_membership.sv
// Mandelbrot set membership test for one Q4.28 point per word.
//
// Channels: i_point takes a word (c_real, c_imag); o_result gives one word
// (in_set) per point, in order. i_cfg writes the iteration limit max_iter
// (reset value 1000); it is taken only while the block is idle.
// A point first gets a range check; unless a component is beyond two it goes
// through the main cardioid and period-2 bulb test, then, if not inside,
// through z = z^2 + c starting at z = c. All products go through one shared
// 32x32 multiplier with two register stages; each iteration passes the states
// SQI, PROD, ESC and STEP, bound by the chain z_re*z_im -> z_im -> z_im^2.
// One point is worked on at a time; i_point.ready is high only when idle,
// so a new point is taken only after the last has left the done state.
// The verdict sits in an output register, so the next point is taken while
// it waits; if the receiver still stalls when the next verdict is ready,
// the block holds in its done state until the register frees.
// Reset (i_rst_n low at a clock edge) returns to idle, drops the pending
// word and restores max_iter to 1000.
`default_nettype none
module mandelbrot_point_membership (
    input  wire            i_clk,
    input  wire            i_rst_n,
    mbpm_point_if.sink     i_point,
    mbpm_cfg_if.sink       i_cfg,
    mbpm_result_if.source  o_result
);

    mbpm_pkg::t_state r_state, n_state;
    logic             r_flag, n_flag;

    logic [mbpm_pkg::ITER_W-1:0] r_max_iter;
    logic [mbpm_pkg::ITER_W-1:0] r_cnt;
    logic                        r_first;

    // Point and working values
    mbpm_pkg::t_fx r_cr, r_ci, r_d, r_xp;
    mbpm_pkg::t_fx r_zr, r_zi, r_sr, r_nr;
    mbpm_pkg::t_fx r_yy, r_yq, r_q, r_qd;
    logic          r_bulb;

    // Shared multiplier
    mbpm_pkg::t_fx                  op_a, op_b;
    mbpm_pkg::t_shift               op_sh;
    logic [mbpm_pkg::PROD_W-1:0]    r_pmag;
    logic                           r_pneg;
    mbpm_pkg::t_shift               r_psh;
    mbpm_pkg::t_fx                  prod_shifted;
    mbpm_pkg::t_fx                  r_res;

    // Output register
    logic r_out_valid, r_in_set;

    // Decisions
    logic                     accept, out_free;
    logic signed [mbpm_pkg::FX_W:0] esc_sum;
    logic                     esc_hit, iter_done, fix_hit, oob_hit, card_hit;
    mbpm_pkg::t_fx            new_re, new_im;

    assign accept   = i_point.valid && i_point.ready;
    assign out_free = !r_out_valid || o_result.ready;

    assign i_point.ready   = (r_state == mbpm_pkg::ST_IDLE);
    assign i_cfg.ready     = (r_state == mbpm_pkg::ST_IDLE);
    assign o_result.valid  = r_out_valid;
    assign o_result.in_set = r_in_set;

    // Escape: |z|^2 > 4 with both squares truncated, never on z = c itself
    assign esc_sum   = $signed({r_sr[mbpm_pkg::FX_W-1], r_sr})
                     + $signed({r_res[mbpm_pkg::FX_W-1], r_res});
    assign esc_hit   = !r_first && (esc_sum > $signed({mbpm_pkg::FX_FOUR[mbpm_pkg::FX_W-1],
                                                       mbpm_pkg::FX_FOUR}));
    assign iter_done = (r_cnt == r_max_iter);
    assign new_re    = r_sr - r_res + r_cr;
    assign new_im    = r_res + r_ci;
    assign fix_hit   = (r_nr == r_zr) && (new_im == r_zi);
    assign oob_hit   = mbpm_pkg::out_of_two(r_nr) || mbpm_pkg::out_of_two(new_im);
    assign card_hit  = (r_res < r_yq) || r_bulb;

    // Operand selection for the multiplier
    always_comb begin
        op_a  = '0;
        op_b  = '0;
        op_sh = mbpm_pkg::SH_NORM;
        case (r_state)
            mbpm_pkg::ST_RANGE: begin
                op_a = r_ci;
                op_b = r_ci;
            end
            mbpm_pkg::ST_DD: begin
                op_a = r_d;
                op_b = r_d;
            end
            mbpm_pkg::ST_YQ: begin
                op_a  = r_ci;
                op_b  = r_ci;
                op_sh = mbpm_pkg::SH_QTR;
            end
            mbpm_pkg::ST_XP: begin
                op_a = r_xp;
                op_b = r_xp;
            end
            mbpm_pkg::ST_CARD: begin
                op_a = r_q;
                op_b = r_qd;
            end
            mbpm_pkg::ST_SQR: begin
                op_a = r_zr;
                op_b = r_zr;
            end
            mbpm_pkg::ST_SQI: begin
                op_a = r_zi;
                op_b = r_zi;
            end
            mbpm_pkg::ST_PROD: begin
                op_a  = r_zr;
                op_b  = r_zi;
                op_sh = mbpm_pkg::SH_TWICE;
            end
            mbpm_pkg::ST_STEP: begin
                // square of the new real part, used next iteration
                op_a = r_nr;
                op_b = r_nr;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Multiplier stage: exact product of magnitudes
    always_ff @(posedge i_clk) begin
        r_pmag <= mbpm_pkg::PROD_W'(mbpm_pkg::mag_of(op_a))
                * mbpm_pkg::PROD_W'(mbpm_pkg::mag_of(op_b));
        r_pneg <= (op_a < 0) != (op_b < 0);
        r_psh  <= op_sh;
    end

    // Shift stage: truncate magnitude, restore sign
    always_comb begin
        case (r_psh)
            mbpm_pkg::SH_NORM:
                prod_shifted = mbpm_pkg::FX_W'(r_pmag >> mbpm_pkg::FRAC_BITS);
            mbpm_pkg::SH_TWICE:
                prod_shifted = mbpm_pkg::FX_W'(r_pmag >> (mbpm_pkg::FRAC_BITS - 1));
            mbpm_pkg::SH_QTR:
                prod_shifted = mbpm_pkg::FX_W'(r_pmag >> (mbpm_pkg::FRAC_BITS + 2));
            default:
                prod_shifted = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= r_pneg ? -prod_shifted : prod_shifted;
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbpm_pkg::ST_IDLE;
            r_flag  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
        end
    end

    // Next state and verdict
    always_comb begin
        n_state = r_state;
        n_flag  = r_flag;
        case (r_state)
            mbpm_pkg::ST_IDLE: begin
                if (accept) n_state = mbpm_pkg::ST_RANGE;
            end
            mbpm_pkg::ST_RANGE: begin
                if (mbpm_pkg::out_of_two(r_cr) || mbpm_pkg::out_of_two(r_ci))
                    n_state = mbpm_pkg::ST_SQR;
                else
                    n_state = mbpm_pkg::ST_DD;
            end
            mbpm_pkg::ST_DD:    n_state = mbpm_pkg::ST_YQ;
            mbpm_pkg::ST_YQ:    n_state = mbpm_pkg::ST_XP;
            mbpm_pkg::ST_XP:    n_state = mbpm_pkg::ST_QD;
            mbpm_pkg::ST_QD:    n_state = mbpm_pkg::ST_CARD;
            mbpm_pkg::ST_CARD:  n_state = mbpm_pkg::ST_CWAIT;
            mbpm_pkg::ST_CWAIT: n_state = mbpm_pkg::ST_CDEC;
            mbpm_pkg::ST_CDEC: begin
                if (card_hit) begin
                    n_flag  = 1'b1;
                    n_state = mbpm_pkg::ST_DONE;
                end else begin
                    n_state = mbpm_pkg::ST_SQR;
                end
            end
            mbpm_pkg::ST_SQR:  n_state = mbpm_pkg::ST_SQI;
            mbpm_pkg::ST_SQI:  n_state = mbpm_pkg::ST_PROD;
            mbpm_pkg::ST_PROD: n_state = mbpm_pkg::ST_ESC;
            mbpm_pkg::ST_ESC: begin
                if (esc_hit) begin
                    n_flag  = 1'b0;
                    n_state = mbpm_pkg::ST_DONE;
                end else if (iter_done) begin
                    n_flag  = 1'b1;
                    n_state = mbpm_pkg::ST_DONE;
                end else begin
                    n_state = mbpm_pkg::ST_STEP;
                end
            end
            mbpm_pkg::ST_STEP: begin
                if (fix_hit) begin
                    n_flag  = 1'b1;
                    n_state = mbpm_pkg::ST_DONE;
                end else if (oob_hit) begin
                    n_flag  = 1'b0;
                    n_state = mbpm_pkg::ST_DONE;
                end else begin
                    n_state = mbpm_pkg::ST_SQI;
                end
            end
            mbpm_pkg::ST_DONE: begin
                if (out_free) n_state = mbpm_pkg::ST_IDLE;
            end
            default: n_state = mbpm_pkg::ST_IDLE;
        endcase
    end

    // Iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_first <= 1'b1;
        end else if (accept) begin
            r_cnt   <= '0;
            r_first <= 1'b1;
        end else if (r_state == mbpm_pkg::ST_STEP) begin
            r_cnt   <= r_cnt + mbpm_pkg::ITER_W'(1);
            r_first <= 1'b0;
        end
    end

    // Iteration limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= mbpm_pkg::MAX_ITER_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_iter <= i_cfg.max_iter;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mbpm_pkg::ST_IDLE: begin
                if (accept) begin
                    r_cr <= mbpm_pkg::t_fx'(i_point.c_real);
                    r_ci <= mbpm_pkg::t_fx'(i_point.c_imag);
                    r_zr <= mbpm_pkg::t_fx'(i_point.c_real);
                    r_zi <= mbpm_pkg::t_fx'(i_point.c_imag);
                    r_d  <= mbpm_pkg::t_fx'(i_point.c_real) - mbpm_pkg::FX_QUARTER;
                    r_xp <= mbpm_pkg::t_fx'(i_point.c_real) + mbpm_pkg::FX_ONE;
                end
            end
            mbpm_pkg::ST_YQ:   r_yy <= r_res;
            mbpm_pkg::ST_XP:   r_q  <= r_res + r_yy;
            mbpm_pkg::ST_QD: begin
                r_yq <= r_res;
                r_qd <= r_q + r_d;
            end
            mbpm_pkg::ST_CARD: r_bulb <= (r_res + r_yy) < mbpm_pkg::FX_SIXTEENTH;
            mbpm_pkg::ST_PROD: r_sr <= r_res;
            mbpm_pkg::ST_ESC:  r_nr <= new_re;
            mbpm_pkg::ST_STEP: begin
                r_zr <= r_nr;
                r_zi <= new_im;
            end
            default: begin
                r_bulb <= r_bulb;
            end
        endcase
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == mbpm_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mbpm_pkg::ST_DONE && out_free) begin
            r_in_set <= r_flag;
        end
    end

    // An accepted point always starts with the range check
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == mbpm_pkg::ST_RANGE)
        else $error("accepted point did not start the range check");

    // The step count never runs past the limit
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mbpm_pkg::ST_ESC |-> r_cnt <= r_max_iter)
        else $error("iteration count beyond max_iter");

    // After a completed step, z stays within magnitude two per component
    a_z_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbpm_pkg::ST_SQI && !r_first) |->
            !mbpm_pkg::out_of_two(r_zr) && !mbpm_pkg::out_of_two(r_zi))
        else $error("iteration continued with z out of range");

    // A finished verdict is loaded into the output register and the block idles
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbpm_pkg::ST_DONE && out_free) |=>
            r_out_valid && r_state == mbpm_pkg::ST_IDLE)
        else $error("verdict not delivered to output register");

endmodule
`default_nettype wire
